>>> rtl/nsf_pkg.sv
// Shared types, character codes and helper functions for the NMEA sentence framer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nsf_pkg;

    localparam int MAX_LEN_DEFAULT = 128;
    localparam int ID_CHARS = 5;
    localparam int NUM_COUNTERS = 5;
    localparam int COUNT_W = 16;
    localparam int POS_W = 7;

    typedef logic [7:0] char_t;
    typedef logic [COUNT_W-1:0] counter_t;

    typedef enum logic [2:0] {
        ST_WAIT_DOLLAR = 3'd0,
        ST_ID          = 3'd1,
        ST_BODY        = 3'd2,
        ST_CKS_HI      = 3'd3,
        ST_CKS_LO      = 3'd4,
        ST_WAIT_CR     = 3'd5,
        ST_WAIT_LF     = 3'd6
    } parse_state_t;

    typedef enum logic [2:0] {
        EV_BUSY     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_MISMATCH = 3'd2,
        EV_HEADER   = 3'd3,
        EV_CHAR     = 3'd4,
        EV_DIGIT    = 3'd5,
        EV_LINE     = 3'd6
    } event_t;

    // Positions of the counters in the counter bank.
    localparam int CNT_GOOD   = 0;
    localparam int CNT_HEADER = 1;
    localparam int CNT_CHAR   = 2;
    localparam int CNT_CKS    = 3;
    localparam int CNT_LINE   = 4;

    localparam char_t CH_DOLLAR = 8'h24;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_DASH   = 8'h2D;
    localparam char_t CH_UNDER  = 8'h5F;

    function automatic logic is_alnum(input char_t c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_upper_hex(input char_t c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] hex_value(input char_t c);
        char_t d;
        d = (c <= 8'h39) ? (c - 8'h30) : (c - 8'h37);
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/nsf_stream_if.sv
// Valid/ready channel interfaces: received bytes in, framer results out.
// Depends on nsf_pkg for the field types.
`default_nettype none

interface nsf_byte_if import nsf_pkg::*;;
    logic  valid;
    logic  ready;
    char_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsf_result_if import nsf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [2:0]             event_res;
    logic [8*ID_CHARS-1:0]  sentence_id;
    char_t                  computed_sum;
    logic [POS_W-1:0]       byte_position;
    counter_t               good_count;
    counter_t               header_errors;
    counter_t               char_errors;
    counter_t               checksum_errors;
    counter_t               line_end_errors;

    modport source (
        output valid, output event_res, output sentence_id, output computed_sum,
        output byte_position, output good_count, output header_errors,
        output char_errors, output checksum_errors, output line_end_errors,
        input ready
    );
    modport sink (
        input valid, input event_res, input sentence_id, input computed_sum,
        input byte_position, input good_count, input header_errors,
        input char_errors, input checksum_errors, input line_end_errors,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/nmea_sentence_framer.sv
// NMEA 0183 sentence framer: one byte in, one result out per byte, at one byte per
// clock cycle sustained while results are taken. A byte is captured in an input
// register, and then a single pass of the parse state machine updates the sentence
// state and loads the result register. While a result waits to be taken, an empty
// input register still lets one more byte in; once it holds a byte, a stalled
// result stops the byte channel in that same cycle.
// Sentences longer than MAX_LEN-1 bytes restart the framer at the next byte.
// Depends on nsf_pkg and the channel interfaces in nsf_stream_if.sv.
`default_nettype none

module nmea_sentence_framer import nsf_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nsf_byte_if.sink        rx,
    nsf_result_if.source    res
);

    localparam int CNT_W = $clog2(MAX_LEN);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(MAX_LEN - 1);

    // Input register stage.
    logic  in_valid_reg;
    char_t in_byte_reg;
    logic  advance;

    // Sentence state; it doubles as the result payload.
    parse_state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    char_t            xor_reg, xor_next;
    char_t            rsum_reg, rsum_next;
    char_t            id_reg [ID_CHARS];
    char_t            id_next [ID_CHARS];
    counter_t         cnt_reg [NUM_COUNTERS];
    counter_t         cnt_next [NUM_COUNTERS];
    logic             out_valid_reg;
    event_t           event_reg, event_next;

    // Per-byte decode, after the buffer-full restart.
    parse_state_t     cur_state;
    logic [CNT_W-1:0] pos;
    char_t            c;
    logic             alnum;
    logic             hexd;
    logic             body_char;
    logic [NUM_COUNTERS-1:0] bump;
    logic [CNT_W+POS_W-1:0]  pos_ext;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    assign c         = in_byte_reg;
    assign cur_state = (count_reg >= LAST_POS) ? ST_WAIT_DOLLAR : state_reg;
    assign pos       = ((count_reg >= LAST_POS) ? '0 : count_reg) + CNT_W'(1);
    assign alnum     = is_alnum(c);
    assign hexd      = is_upper_hex(c);
    assign body_char = alnum || c == CH_COMMA || c == CH_PERIOD || c == CH_DASH
                       || c == CH_UNDER;

    // Next state and byte position.
    always_comb
    begin
        state_next = ST_WAIT_DOLLAR;
        count_next = '0;
        case (cur_state)
            ST_WAIT_DOLLAR:
            begin
                if (c == CH_DOLLAR)
                begin
                    state_next = ST_ID;
                    count_next = pos;
                end
            end
            ST_ID:
            begin
                if (alnum)
                begin
                    state_next = (pos >= CNT_W'(ID_CHARS + 1)) ? ST_BODY : ST_ID;
                    count_next = pos;
                end
            end
            ST_BODY:
            begin
                if (c == CH_STAR)
                begin
                    state_next = ST_CKS_HI;
                    count_next = pos;
                end
                else if (c == CH_CR)
                begin
                    state_next = ST_WAIT_LF;
                    count_next = pos;
                end
                else if (body_char)
                begin
                    state_next = ST_BODY;
                    count_next = pos;
                end
            end
            ST_CKS_HI:
            begin
                if (hexd)
                begin
                    state_next = ST_CKS_LO;
                    count_next = pos;
                end
            end
            ST_CKS_LO:
            begin
                if (hexd)
                begin
                    state_next = ST_WAIT_CR;
                    count_next = pos;
                end
            end
            ST_WAIT_CR:
            begin
                if (c == CH_CR)
                begin
                    state_next = ST_WAIT_LF;
                    count_next = pos;
                end
            end
            // A line feed ends the sentence either way, and anything else is an error.
            ST_WAIT_LF:
            begin
                state_next = ST_WAIT_DOLLAR;
                count_next = '0;
            end
            default:
            begin
                state_next = ST_WAIT_DOLLAR;
                count_next = '0;
            end
        endcase
    end

    // Event code, checksum, ID capture and counter selection.
    always_comb
    begin
        event_next = EV_BUSY;
        xor_next   = xor_reg;
        rsum_next  = rsum_reg;
        bump       = '0;
        for (int i = 0; i < ID_CHARS; i++)
        begin
            id_next[i] = id_reg[i];
        end
        case (cur_state)
            ST_WAIT_DOLLAR:
            begin
                if (c == CH_DOLLAR)
                begin
                    xor_next  = '0;
                    rsum_next = '0;
                end
                else
                begin
                    event_next       = EV_HEADER;
                    bump[CNT_HEADER] = 1'b1;
                end
            end
            ST_ID:
            begin
                if (alnum)
                begin
                    xor_next = xor_reg ^ c;
                    for (int i = 0; i < ID_CHARS; i++)
                    begin
                        if (pos == CNT_W'(i + 2))
                        begin
                            id_next[i] = c;
                        end
                    end
                end
                else
                begin
                    event_next     = EV_CHAR;
                    bump[CNT_CHAR] = 1'b1;
                end
            end
            ST_BODY:
            begin
                if (c == CH_STAR)
                begin
                    event_next = EV_BUSY;
                end
                else if (c == CH_CR)
                begin
                    // Without a checksum field the sentence always matches.
                    xor_next  = '0;
                    rsum_next = '0;
                end
                else if (body_char)
                begin
                    xor_next = xor_reg ^ c;
                end
                else
                begin
                    event_next     = EV_CHAR;
                    bump[CNT_CHAR] = 1'b1;
                end
            end
            ST_CKS_HI:
            begin
                if (hexd)
                begin
                    rsum_next = {hex_value(c), 4'h0};
                end
                else
                begin
                    event_next    = EV_DIGIT;
                    bump[CNT_CKS] = 1'b1;
                end
            end
            ST_CKS_LO:
            begin
                if (hexd)
                begin
                    rsum_next = rsum_reg + {4'h0, hex_value(c)};
                end
                else
                begin
                    event_next    = EV_DIGIT;
                    bump[CNT_CKS] = 1'b1;
                end
            end
            ST_WAIT_CR:
            begin
                if (c != CH_CR)
                begin
                    event_next     = EV_LINE;
                    bump[CNT_LINE] = 1'b1;
                end
            end
            ST_WAIT_LF:
            begin
                if (c != CH_LF)
                begin
                    event_next     = EV_LINE;
                    bump[CNT_LINE] = 1'b1;
                end
                else if (xor_reg == rsum_reg)
                begin
                    event_next     = EV_GOOD;
                    bump[CNT_GOOD] = 1'b1;
                end
                else
                begin
                    event_next    = EV_MISMATCH;
                    bump[CNT_CKS] = 1'b1;
                end
            end
            default:
            begin
                event_next = EV_BUSY;
            end
        endcase
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            cnt_next[i] = (bump[i] && cnt_reg[i] != '1) ? cnt_reg[i] + counter_t'(1)
                                                        : cnt_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_WAIT_DOLLAR;
            count_reg     <= '0;
            xor_reg       <= '0;
            rsum_reg      <= '0;
            for (int i = 0; i < ID_CHARS; i++)
            begin
                id_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                count_reg     <= count_next;
                xor_reg       <= xor_next;
                rsum_reg      <= rsum_next;
                id_reg        <= id_next;
                cnt_reg       <= cnt_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            event_reg <= event_next;
        end
    end

    // The state registers only change when a new result is loaded, so they
    // drive the result payload directly.
    assign pos_ext = (CNT_W + POS_W)'(count_reg);

    assign res.valid           = out_valid_reg;
    assign res.event_res       = event_reg;
    assign res.sentence_id     = {id_reg[0], id_reg[1], id_reg[2], id_reg[3], id_reg[4]};
    assign res.computed_sum    = xor_reg;
    assign res.byte_position   = pos_ext[POS_W-1:0];
    assign res.good_count      = cnt_reg[CNT_GOOD];
    assign res.header_errors   = cnt_reg[CNT_HEADER];
    assign res.char_errors     = cnt_reg[CNT_CHAR];
    assign res.checksum_errors = cnt_reg[CNT_CKS];
    assign res.line_end_errors = cnt_reg[CNT_LINE];

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for nmea_sentence_framer: byte-serial sentences in, one result checked per byte.
// A scoreboard class predicts each result; the interfaces come from rtl/nsf_stream_if.sv
// and the types and character codes come from nsf_pkg.
`timescale 1ns / 1ps

module tb;
    import nsf_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEFAULT;
    localparam int BYTE_TARGET = 1300;

    typedef struct {
        event_t      ev;
        logic [39:0] id;
        char_t       sum;
        logic [6:0]  pos;
        counter_t    counts [NUM_COUNTERS];
    } frame_result_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_LOWER_HEX,
        FLAW_ID_CHAR,
        FLAW_BODY_CHAR,
        FLAW_NO_CR,
        FLAW_NO_LF,
        FLAW_TRUNCATE,
        FLAW_WILD_BYTE
    } flaw_t;

    class framer_scoreboard;
        parse_state_t    st;
        int unsigned     fill;
        int unsigned     max_len;
        char_t           xsum;
        char_t           rsum;
        char_t           id_q [ID_CHARS];
        counter_t        counts [NUM_COUNTERS];
        frame_result_t   expected_q [$];
        int unsigned     errors;

        function new(int unsigned len);
            max_len = len;
            st = ST_WAIT_DOLLAR;
            fill = 0;
            xsum = '0;
            rsum = '0;
            errors = 0;
            foreach (id_q[k]) id_q[k] = '0;
            foreach (counts[k]) counts[k] = '0;
        endfunction

        static function bit alnum(char_t c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
        endfunction

        static function bit punct(char_t c);
            return c == CH_COMMA || c == CH_PERIOD || c == CH_DASH || c == CH_UNDER;
        endfunction

        static function bit hex_digit(char_t c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
        endfunction

        // Digits carry their value in the low nibble; A-F carry 1-6 there.
        static function logic [3:0] nibble(char_t c);
            return (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
        endfunction

        function void bump(int idx);
            if (counts[idx] != 16'hFFFF)
                counts[idx]++;
        endfunction

        function event_t abort(int idx, event_t ev);
            bump(idx);
            st = ST_WAIT_DOLLAR;
            fill = 0;
            return ev;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(char_t c);
            frame_result_t r;
            event_t ev;
            ev = EV_BUSY;
            // A full buffer drops the sentence and treats this byte as a fresh start.
            if (fill >= max_len - 1)
            begin
                st = ST_WAIT_DOLLAR;
                fill = 0;
            end
            fill++;
            case (st)
                ST_WAIT_DOLLAR:
                begin
                    if (c == CH_DOLLAR)
                    begin
                        st = ST_ID;
                        xsum = '0;
                        rsum = '0;
                    end
                    else
                        ev = abort(CNT_HEADER, EV_HEADER);
                end
                ST_ID:
                begin
                    if (alnum(c))
                    begin
                        if (fill >= 2 && fill <= 6)
                            id_q[fill-2] = c;
                        xsum ^= c;
                        if (fill >= 6)
                            st = ST_BODY;
                    end
                    else
                        ev = abort(CNT_CHAR, EV_CHAR);
                end
                ST_BODY:
                begin
                    if (c == CH_STAR)
                        st = ST_CKS_HI;
                    else if (c == CH_CR)
                    begin
                        // No checksum field: the sentence is accepted as it stands.
                        xsum = '0;
                        rsum = '0;
                        st = ST_WAIT_LF;
                    end
                    else if (alnum(c) || punct(c))
                        xsum ^= c;
                    else
                        ev = abort(CNT_CHAR, EV_CHAR);
                end
                ST_CKS_HI:
                begin
                    if (hex_digit(c))
                    begin
                        rsum = {nibble(c), 4'h0};
                        st = ST_CKS_LO;
                    end
                    else
                        ev = abort(CNT_CKS, EV_DIGIT);
                end
                ST_CKS_LO:
                begin
                    if (hex_digit(c))
                    begin
                        rsum = rsum + char_t'(nibble(c));
                        st = ST_WAIT_CR;
                    end
                    else
                        ev = abort(CNT_CKS, EV_DIGIT);
                end
                ST_WAIT_CR:
                begin
                    if (c == CH_CR)
                        st = ST_WAIT_LF;
                    else
                        ev = abort(CNT_LINE, EV_LINE);
                end
                ST_WAIT_LF:
                begin
                    if (c == CH_LF)
                    begin
                        if (xsum == rsum)
                        begin
                            bump(CNT_GOOD);
                            ev = EV_GOOD;
                        end
                        else
                        begin
                            bump(CNT_CKS);
                            ev = EV_MISMATCH;
                        end
                        st = ST_WAIT_DOLLAR;
                        fill = 0;
                    end
                    else
                        ev = abort(CNT_LINE, EV_LINE);
                end
                default:
                begin
                    st = ST_WAIT_DOLLAR;
                    fill = 0;
                end
            endcase
            r.ev = ev;
            r.id = '0;
            foreach (id_q[k]) r.id = {r.id[31:0], id_q[k]};
            r.sum = xsum;
            r.pos = fill[6:0];
            foreach (counts[k]) r.counts[k] = counts[k];
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t tb: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, longint unsigned got, longint unsigned want);
            if (got != want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(frame_result_t got);
            frame_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with event %0d and no byte outstanding", got.ev));
                return;
            end
            want = expected_q.pop_front();
            check_field("event_res", got.ev, want.ev);
            check_field("sentence_id", got.id, want.id);
            check_field("computed_sum", got.sum, want.sum);
            check_field("byte_position", got.pos, want.pos);
            check_field("good_count", got.counts[CNT_GOOD], want.counts[CNT_GOOD]);
            check_field("header_errors", got.counts[CNT_HEADER], want.counts[CNT_HEADER]);
            check_field("char_errors", got.counts[CNT_CHAR], want.counts[CNT_CHAR]);
            check_field("checksum_errors", got.counts[CNT_CKS], want.counts[CNT_CKS]);
            check_field("line_end_errors", got.counts[CNT_LINE], want.counts[CNT_LINE]);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nsf_byte_if   rx_bus ();
    nsf_result_if res_bus ();

    nmea_sentence_framer #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus),
        .res   (res_bus)
    );

    always #2 clk = ~clk;

    framer_scoreboard sb;
    char_t            line_q [$];
    int unsigned      sent_bytes;
    int unsigned      burst_left;
    bit               calm;
    logic [31:0]      ready_pattern;
    logic [4:0]       ready_idx;

    // Result side: ready follows a 32-bit pattern that is redrawn each time it runs out.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            ready_idx <= '0;
            ready_pattern <= '1;
        end
        else
        begin
            res_bus.ready <= ready_pattern[ready_idx];
            ready_idx <= ready_idx + 5'd1;
            if (ready_idx == 5'd31)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern <= '1;
                    1: ready_pattern <= $urandom & $urandom;
                    default: ready_pattern <= $urandom;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : take_result
        frame_result_t got;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.ev = event_t'(res_bus.event_res);
            got.id = res_bus.sentence_id;
            got.sum = res_bus.computed_sum;
            got.pos = res_bus.byte_position;
            got.counts[CNT_GOOD] = res_bus.good_count;
            got.counts[CNT_HEADER] = res_bus.header_errors;
            got.counts[CNT_CHAR] = res_bus.char_errors;
            got.counts[CNT_CKS] = res_bus.checksum_errors;
            got.counts[CNT_LINE] = res_bus.line_end_errors;
            sb.check_result(got);
        end
    end

    function automatic char_t rand_alnum();
        int unsigned idx;
        idx = $urandom_range(0, 61);
        if (idx < 10)
            return char_t'(8'h30 + idx);
        else if (idx < 36)
            return char_t'(8'h41 + idx - 10);
        return char_t'(8'h61 + idx - 36);
    endfunction

    function automatic char_t rand_body_char();
        case ($urandom_range(0, 69))
            62: return CH_COMMA;
            63: return CH_PERIOD;
            64: return CH_DASH;
            65: return CH_UNDER;
            66, 67: return CH_COMMA;
            68, 69: return CH_PERIOD;
            default: return rand_alnum();
        endcase
    endfunction

    function automatic char_t hex_char(logic [3:0] n);
        return (n < 4'd10) ? char_t'(8'h30 + n) : char_t'(8'h37 + n);
    endfunction

    // Appends the checksum field, if asked for, and the line end to line_q.
    function automatic void close_line(bit with_sum);
        char_t s;
        s = '0;
        for (int k = 1; k < line_q.size(); k++)
            s ^= line_q[k];
        if (with_sum)
        begin
            line_q.push_back(CH_STAR);
            line_q.push_back(hex_char(s[7:4]));
            line_q.push_back(hex_char(s[3:0]));
        end
        line_q.push_back(CH_CR);
        line_q.push_back(CH_LF);
    endfunction

    function automatic void build_sentence(bit go_long);
        bit          with_sum;
        int unsigned body_len;
        int unsigned last;
        char_t       c;
        flaw_t       flaw;
        line_q = {};
        line_q.push_back(CH_DOLLAR);
        repeat (ID_CHARS) line_q.push_back(rand_alnum());
        body_len = go_long ? $urandom_range(110, 150) : $urandom_range(0, 24);
        repeat (body_len) line_q.push_back(rand_body_char());
        with_sum = $urandom_range(0, 3) != 0;
        close_line(with_sum);
        last = line_q.size() - 1;
        flaw = ($urandom_range(0, 9) < 4) ? flaw_t'($urandom_range(1, 8)) : FLAW_NONE;
        case (flaw)
            FLAW_SUM:
                if (with_sum)
                    line_q[last-3] = hex_char(4'($urandom_range(0, 15)));
            FLAW_LOWER_HEX:
                if (with_sum)
                    line_q[last-2-$urandom_range(0, 1)] = char_t'(8'h61 + $urandom_range(0, 5));
            FLAW_ID_CHAR:
            begin
                c = char_t'($urandom_range(0, 255));
                if (framer_scoreboard::alnum(c))
                    c[7] = 1'b1;
                line_q[$urandom_range(1, ID_CHARS)] = c;
            end
            FLAW_BODY_CHAR:
            begin
                c = ($urandom_range(0, 3) == 0) ? CH_DOLLAR : char_t'($urandom_range(0, 255));
                if (framer_scoreboard::alnum(c) || framer_scoreboard::punct(c) ||
                    c == CH_STAR || c == CH_CR)
                    c[7] = 1'b1;
                line_q.insert($urandom_range(ID_CHARS + 1, last - 1 - (with_sum ? 3 : 0)), c);
            end
            FLAW_NO_CR:
            begin
                c = char_t'($urandom_range(0, 255));
                line_q[last-1] = (c == CH_CR) ? CH_LF : c;
            end
            FLAW_NO_LF:
            begin
                c = char_t'($urandom_range(0, 255));
                line_q[last] = (c == CH_LF) ? CH_CR : c;
            end
            FLAW_TRUNCATE:
                line_q = line_q[0:$urandom_range(0, last - 1)];
            FLAW_WILD_BYTE:
                line_q[$urandom_range(0, last)] = char_t'($urandom_range(0, 255));
            default: ;
        endcase
    endfunction

    // Valid stays high across a burst; a burst ends with a random gap unless calm is set.
    task automatic push_byte(input char_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                rx_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        rx_bus.valid <= 1'b1;
        rx_bus.rx_byte <= c;
        @(posedge clk);
        while (!rx_bus.ready) @(posedge clk);
        sb.note_byte(c);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_line();
        foreach (line_q[k]) push_byte(line_q[k]);
    endtask

    // Holds the byte channel idle until every outstanding result has been taken.
    task automatic drain();
        rx_bus.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        int unsigned n;
        bit          paused;
        sb = new(MAX_LEN);
        rx_bus.valid = 1'b0;
        rx_bus.rx_byte = '0;
        sent_bytes = 0;
        burst_left = 0;
        calm = 1'b0;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme bytes outside a sentence, then a checksummed sentence that
        // uses every body punctuation mark and one without a checksum.
        push_byte(8'h00);
        push_byte(8'hFF);
        line_q = {CH_DOLLAR, 8'h41, 8'h30, 8'h7A, 8'h39, 8'h5A,
                  CH_COMMA, CH_PERIOD, CH_DASH, CH_UNDER};
        close_line(1'b1);
        send_line();
        line_q = {CH_DOLLAR, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A};
        close_line(1'b0);
        send_line();
        drain();

        n = 0;
        while (sent_bytes < BYTE_TARGET)
        begin
            calm = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 4)) push_byte(char_t'($urandom_range(0, 255)));
            // A few over-long sentences make sure the buffer-full restart is exercised.
            build_sentence(n == 2 || n == 25 || $urandom_range(0, 39) == 0);
            send_line();
            n++;
            if (!paused && sent_bytes >= BYTE_TARGET / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("[nmea_sentence_framer] OK");
        else
            $display("[nmea_sentence_framer] ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[nmea_sentence_framer] ERROR");
        $finish;
    end

endmodule
